### sv/rwct_pkg.sv
`default_nettype none

package rwct_pkg;

    // Defaults for the top-level parameters
    localparam int SCREEN_H_DEF      = 512;
    localparam int TEXTURE_SLOTS_DEF = 4;

    // Field and datapath widths
    localparam int TEX_DIM_W = 11;
    localparam int DIST_W    = 24;
    localparam int FRAC_W    = 16;
    localparam int PROD_W    = TEX_DIM_W + DIST_W;
    localparam int POS_W     = 26;
    localparam int INC_W     = 32;
    localparam int MASK_W    = 4;
    localparam int CFG_IDX_W = 2;

    // Distances at or below this (0.0001 in Q8.16) are rejected
    localparam logic [DIST_W-1:0] MIN_DIST = DIST_W'(6);
    localparam logic [POS_W-1:0]  POS_MAX  = {POS_W{1'b1}};

    typedef enum logic [2:0] {
        ST_PIXEL     = 3'd0,
        ST_COLUMN    = 3'd1,
        ST_TOO_CLOSE = 3'd2,
        ST_UNLOADED  = 3'd3,
        ST_NO_COLUMN = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEX_W  = 2'd0,
        CFG_TEX_H  = 2'd1,
        CFG_MASK   = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_INC,
        S_DIV_INC,
        S_SET_START,
        S_SET_COL,
        S_WAIT_INC,
        S_WAIT_SPAN
    } t_state;

endpackage

`default_nettype wire

### sv/rwct_divider.sv
`default_nettype none

module rwct_divider #(
    parameter int DVD_W = rwct_pkg::PROD_W,
    parameter int DVS_W = rwct_pkg::DIST_W
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DVD_W-1:0] i_dividend,
    input  wire logic [DVS_W-1:0] i_divisor,
    output logic                  o_done,
    output logic [DVD_W-1:0]      o_quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DVS_W:0]   w_trial;
    logic             w_ge;
    logic [DVS_W:0]   w_sub;
    logic [DVS_W-1:0] n_rem;

    // One restoring step: bring down the next dividend bit, subtract if it fits
    always_comb begin
        w_trial = {r_rem, r_quo[DVD_W-1]};
        w_ge    = (w_trial >= {1'b0, r_dvs});
        w_sub   = w_trial - {1'b0, r_dvs};
        n_rem   = w_ge ? w_sub[DVS_W-1:0] : w_trial[DVS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_quo  <= '0;
            r_rem  <= '0;
            r_dvs  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
                r_cnt  <= CNT_W'(DVD_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_quo <= {r_quo[DVD_W-2:0], w_ge};
                r_rem <= n_rem;
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

### sv/raycast_wall_column_texturer.sv
// Step word (func 1): result the cycle after acceptance, a new step every cycle.
// Begin word (func 0): the column-ready word comes after the set-up states MUL_INC, DIV_INC,
//   SET_START and SET_COL and one shared divider pass for the wall height; next word at the same
//   edge. The texel step is a shift for a power-of-two SCREEN_H, else a further divider pass.
// Rejected begin words answer the cycle after acceptance; the receiver cannot stall results.
// Active-low sync reset clears all but operand and result fields; texture resets to 64x64.
`default_nettype none

module raycast_wall_column_texturer #(
    parameter int SCREEN_H      = rwct_pkg::SCREEN_H_DEF,
    parameter int TEXTURE_SLOTS = rwct_pkg::TEXTURE_SLOTS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic        i_func,
    input  wire logic [9:0]  i_column_x,
    input  wire logic [23:0] i_wall_distance,
    input  wire logic [1:0]  i_texture_select,
    input  wire logic signed [16:0] i_hit_fraction,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [10:0] i_cfg_data,
    output logic             o_strobe,
    output logic [2:0]       o_status,
    output logic [8:0]       o_pixel_row,
    output logic [9:0]       o_pixel_col,
    output logic [9:0]       o_texel_row,
    output logic [9:0]       o_texel_col,
    output logic [1:0]       o_texture_id,
    output logic [9:0]       o_span_length,
    output logic             o_last
);

    localparam int HW        = $clog2(SCREEN_H + 1);
    localparam int TEX_DIM_W = rwct_pkg::TEX_DIM_W;
    localparam int DIST_W    = rwct_pkg::DIST_W;
    localparam int PROD_W    = rwct_pkg::PROD_W;
    localparam int POS_W     = rwct_pkg::POS_W;
    localparam int INC_W     = rwct_pkg::INC_W;
    localparam int FRAC_W    = rwct_pkg::FRAC_W;
    localparam bit H_POW2    = ((SCREEN_H & (SCREEN_H - 1)) == 0);
    localparam int H_LOG2    = $clog2(SCREEN_H);
    localparam logic [HW-1:0]     H_V      = HW'(SCREEN_H);
    localparam logic [PROD_W-1:0] H_P      = PROD_W'(SCREEN_H);
    localparam logic [PROD_W-1:0] H_SCALED = H_P << 16;

    // Control and configuration registers
    rwct_pkg::t_state             r_state, n_state;
    logic [TEX_DIM_W-1:0]         r_tex_w, r_tex_h;
    logic [rwct_pkg::MASK_W-1:0]  r_mask;
    logic                         r_active, n_active;

    // Column state
    logic [HW-1:0]     r_left, n_left;
    logic [HW-1:0]     r_row, n_row;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [INC_W-1:0]  r_inc, n_inc;
    logic [9:0]        r_tcol, n_tcol;
    logic [9:0]        r_col, n_col;
    logic [1:0]        r_slot, n_slot;
    logic [DIST_W-1:0] r_dist, n_dist;
    logic [FRAC_W-1:0] r_frac, n_frac;
    logic [PROD_W-1:0] r_prod;

    // Result word registers
    logic               r_strobe, n_strobe;
    rwct_pkg::t_status  r_status, n_status;
    logic [8:0]         r_orow, n_orow;
    logic [9:0]         r_ocol, n_ocol;
    logic [9:0]         r_otrow, n_otrow;
    logic [9:0]         r_otcol, n_otcol;
    logic [1:0]         r_oid, n_oid;
    logic [9:0]         r_olen, n_olen;
    logic               r_olast, n_olast;

    // Shared multiplier and divider hookup
    logic [TEX_DIM_W-1:0] w_mul_a;
    logic [DIST_W-1:0]    w_mul_b;
    logic [16:0]          w_one_minus;
    logic                 w_div_start;
    logic [PROD_W-1:0]    w_div_dvd;
    logic [DIST_W-1:0]    w_div_dvs;
    logic                 w_div_done;
    logic [PROD_W-1:0]    w_quo;

    // Pixel step helpers
    logic [9:0]           w_trow_raw;
    logic [TEX_DIM_W-1:0] w_hm1;
    logic [9:0]           w_trow;
    logic [POS_W+6:0]     w_pos_sum;
    logic                 w_loaded;
    logic [PROD_W-2:0]    w_start_raw;
    logic [PROD_W-17:0]   w_tc_raw;
    logic [HW-1:0]        w_span;
    logic [PROD_W-1:0]    w_inc_shift;

    assign o_busy      = (r_state != rwct_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_w <= TEX_DIM_W'(64);
            r_tex_h <= TEX_DIM_W'(64);
            r_mask  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (rwct_pkg::t_cfg_idx'(i_cfg_index))
                rwct_pkg::CFG_TEX_W: r_tex_w <= i_cfg_data;
                rwct_pkg::CFG_TEX_H: r_tex_h <= i_cfg_data;
                rwct_pkg::CFG_MASK:  r_mask  <= i_cfg_data[rwct_pkg::MASK_W-1:0];
                default: ;
            endcase
        end
    end

    // Select multiplier operands per sequencer step
    always_comb begin
        w_one_minus = 17'h10000 - r_dist[16:0];
        case (r_state)
            rwct_pkg::S_MUL_INC: begin
                w_mul_a = r_tex_h;
                w_mul_b = r_dist;
            end
            rwct_pkg::S_DIV_INC: begin
                w_mul_a = r_tex_h;
                w_mul_b = DIST_W'(w_one_minus);
            end
            default: begin
                w_mul_a = r_tex_w;
                w_mul_b = DIST_W'(r_frac);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= {{DIST_W{1'b0}}, w_mul_a} * {{TEX_DIM_W{1'b0}}, w_mul_b};
    end

    // Divider: the texel step unless it is a shift, then the projected wall height
    always_comb begin
        w_div_start = (r_state == rwct_pkg::S_DIV_INC) ||
                      ((r_state == rwct_pkg::S_WAIT_INC) && w_div_done);
        if ((r_state == rwct_pkg::S_DIV_INC) && !H_POW2) begin
            w_div_dvd = r_prod;
            w_div_dvs = DIST_W'(SCREEN_H);
        end else begin
            w_div_dvd = H_SCALED;
            w_div_dvs = r_dist;
        end
    end

    rwct_divider #(
        .DVD_W (PROD_W),
        .DVS_W (DIST_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dvd),
        .i_divisor  (w_div_dvs),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // Datapath helpers
    always_comb begin
        w_trow_raw  = r_pos[POS_W-1:16];
        w_hm1       = r_tex_h - TEX_DIM_W'(1);
        if (r_tex_h == '0) begin
            w_trow = '0;
        end else if ({1'b0, w_trow_raw} > w_hm1) begin
            w_trow = w_hm1[9:0];
        end else begin
            w_trow = w_trow_raw;
        end
        w_pos_sum   = {7'b0, r_pos} + {1'b0, r_inc};
        w_loaded    = (int'(i_texture_select) < TEXTURE_SLOTS) && r_mask[i_texture_select];
        w_start_raw = r_prod[PROD_W-1:1];
        w_tc_raw    = r_prod[PROD_W-1:16];
        w_span      = (w_quo > H_P) ? H_V : w_quo[HW-1:0];
        w_inc_shift = r_prod >> H_LOG2;
    end

    // Sequencer: next state, column state and result word
    always_comb begin
        n_state  = r_state;
        n_active = r_active;
        n_left   = r_left;
        n_row    = r_row;
        n_pos    = r_pos;
        n_inc    = r_inc;
        n_tcol   = r_tcol;
        n_col    = r_col;
        n_slot   = r_slot;
        n_dist   = r_dist;
        n_frac   = r_frac;
        n_strobe = 1'b0;
        n_status = rwct_pkg::ST_PIXEL;
        n_orow   = '0;
        n_ocol   = '0;
        n_otrow  = '0;
        n_otcol  = '0;
        n_oid    = '0;
        n_olen   = '0;
        n_olast  = 1'b0;

        unique case (r_state)
            rwct_pkg::S_IDLE: begin
                if (i_start && i_func) begin
                    // Emit one pixel of the active span, or a no-column word if none is active
                    n_strobe = 1'b1;
                    if (!r_active) begin
                        n_status = rwct_pkg::ST_NO_COLUMN;
                    end else begin
                        n_status = rwct_pkg::ST_PIXEL;
                        n_orow   = 9'(r_row);
                        n_ocol   = r_col;
                        n_otrow  = w_trow;
                        n_otcol  = r_tcol;
                        n_oid    = r_slot;
                        n_olast  = (r_left == HW'(1));
                        n_pos    = (w_pos_sum > (POS_W+7)'(rwct_pkg::POS_MAX)) ?
                                   rwct_pkg::POS_MAX : w_pos_sum[POS_W-1:0];
                        n_row    = r_row + HW'(1);
                        if (r_left != '0) begin
                            n_left = r_left - HW'(1);
                        end
                        if (r_left <= HW'(1)) begin
                            n_active = 1'b0;
                        end
                    end
                end else if (i_start) begin
                    // Begin word: drop any active column, then check it
                    n_active = 1'b0;
                    if (i_wall_distance <= rwct_pkg::MIN_DIST) begin
                        n_strobe = 1'b1;
                        n_status = rwct_pkg::ST_TOO_CLOSE;
                    end else if (!w_loaded) begin
                        n_strobe = 1'b1;
                        n_status = rwct_pkg::ST_UNLOADED;
                    end else begin
                        n_dist  = i_wall_distance;
                        n_frac  = i_hit_fraction[16] ? '0 : i_hit_fraction[FRAC_W-1:0];
                        n_col   = i_column_x;
                        n_slot  = i_texture_select;
                        n_state = rwct_pkg::S_MUL_INC;
                    end
                end
            end
            rwct_pkg::S_MUL_INC: begin
                n_state = rwct_pkg::S_DIV_INC;
            end
            rwct_pkg::S_DIV_INC: begin
                // Power-of-two screen height: the texel step is a plain shift
                if (H_POW2) begin
                    n_inc = (w_inc_shift[PROD_W-1:INC_W] != '0) ? {INC_W{1'b1}} :
                            w_inc_shift[INC_W-1:0];
                end
                n_state = rwct_pkg::S_SET_START;
            end
            rwct_pkg::S_SET_START: begin
                // Texture start offset, only for walls nearer than one unit
                if (r_dist[DIST_W-1:16] != '0) begin
                    n_pos = '0;
                end else if (w_start_raw > (PROD_W-1)'(rwct_pkg::POS_MAX)) begin
                    n_pos = rwct_pkg::POS_MAX;
                end else begin
                    n_pos = w_start_raw[POS_W-1:0];
                end
                n_state = rwct_pkg::S_SET_COL;
            end
            rwct_pkg::S_SET_COL: begin
                n_tcol  = (w_tc_raw > (PROD_W-16)'(1023)) ? 10'd1023 : w_tc_raw[9:0];
                n_state = H_POW2 ? rwct_pkg::S_WAIT_SPAN : rwct_pkg::S_WAIT_INC;
            end
            rwct_pkg::S_WAIT_INC: begin
                if (w_div_done) begin
                    n_inc   = (w_quo[PROD_W-1:INC_W] != '0) ? {INC_W{1'b1}} :
                              w_quo[INC_W-1:0];
                    n_state = rwct_pkg::S_WAIT_SPAN;
                end
            end
            rwct_pkg::S_WAIT_SPAN: begin
                if (w_div_done) begin
                    n_left   = w_span;
                    n_row    = (H_V - w_span) >> 1;
                    n_active = (w_span != '0);
                    n_strobe = 1'b1;
                    n_status = rwct_pkg::ST_COLUMN;
                    n_orow   = 9'((H_V - w_span) >> 1);
                    n_ocol   = r_col;
                    n_otcol  = r_tcol;
                    n_oid    = r_slot;
                    n_olen   = 10'(w_span);
                    n_state  = rwct_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rwct_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rwct_pkg::S_IDLE;
            r_active <= 1'b0;
            r_left   <= '0;
            r_row    <= '0;
            r_pos    <= '0;
            r_inc    <= '0;
            r_tcol   <= '0;
            r_col    <= '0;
            r_slot   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_active <= n_active;
            r_left   <= n_left;
            r_row    <= n_row;
            r_pos    <= n_pos;
            r_inc    <= n_inc;
            r_tcol   <= n_tcol;
            r_col    <= n_col;
            r_slot   <= n_slot;
            r_strobe <= n_strobe;
        end
    end

    // Hold operands and the result word
    always_ff @(posedge i_clk) begin
        r_dist   <= n_dist;
        r_frac   <= n_frac;
        r_status <= n_status;
        r_orow   <= n_orow;
        r_ocol   <= n_ocol;
        r_otrow  <= n_otrow;
        r_otcol  <= n_otcol;
        r_oid    <= n_oid;
        r_olen   <= n_olen;
        r_olast  <= n_olast;
    end

    assign o_strobe      = r_strobe;
    assign o_status      = r_status;
    assign o_pixel_row   = r_orow;
    assign o_pixel_col   = r_ocol;
    assign o_texel_row   = r_otrow;
    assign o_texel_col   = r_otcol;
    assign o_texture_id  = r_oid;
    assign o_span_length = r_olen;
    assign o_last        = r_olast;

    // Leaving the begin sequence always delivers the column-ready word
    a_busy_end_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $fell(o_busy) |-> o_strobe && (o_status == rwct_pkg::ST_COLUMN))
        else $error("begin sequence ended without a column-ready word");

    // The final pixel of a span leaves no active column behind
    a_last_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_status == rwct_pkg::ST_PIXEL) && o_last |-> !r_active)
        else $error("column still active after its last pixel");

    // An active column always has pixels left
    a_active_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_left != '0))
        else $error("active column with no pixels left");

endmodule

`default_nettype wire
